### rtl/mexp_pkg.sv
// Shared types, constants and register codes for the modular exponentiation block.
package mexp_pkg;

	localparam int WIDTH     = 32;
	localparam int IDX_W     = $clog2(WIDTH);
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(1);

	typedef struct packed {
		logic [WIDTH-1:0] base_value;
		logic             last_item;
	} item_t;

	typedef struct packed {
		logic [WIDTH-1:0] result_value;
		logic             last_result;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RED,
		ST_RBASE,
		ST_SQS,
		ST_SQ,
		ST_SQT,
		ST_MLS,
		ST_ML,
		ST_MLT,
		ST_ENX,
		ST_FIN
	} state_t;

	typedef enum logic {
		OP_SQUARE,
		OP_MULT
	} opsel_t;

	typedef struct packed {
		logic   load;
		logic   setup;
		opsel_t opsel;
		logic   step;
		logic   take_base;
		logic   take_acc;
		logic   exp_next;
		logic   finish;
	} cmd_t;

	typedef struct packed {
		logic mul_last;
		logic exp_bit;
		logic exp_last;
	} status_t;

endpackage

### rtl/modular_exponentiation.sv
// Top level of the modular exponentiation block: sequencer plus datapath.
//
//   channel   handshake               word
//   item      start / busy            item (base_value, last_item)
//   result    done (one-cycle strobe) result (result_value, last_result)
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item at a time; the shared bit-serial multiplier handles every product.
// busy stays high until the result is in its output register.
// Reset sets modulus and exponent to 1 and returns the sequencer to idle.
// The receiver cannot stall; cfg_ready is always high.
// The user must write the keys only while idle; the block itself does not enforce it.
module modular_exponentiation (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  mexp_pkg::item_t                item,
	output logic                           done,
	output mexp_pkg::result_t              result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mexp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mexp_pkg::WIDTH-1:0]     cfg_data
);
	import mexp_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	mexp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	mexp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.cmd       (cmd),
		.status    (status),
		.result    (result),
		.done      (done)
	);

endmodule

### rtl/mexp_ctrl.sv
// Sequencer for square-and-multiply: drives the datapath one command word per cycle.
module mexp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  mexp_pkg::status_t status,
	output logic             busy,
	output mexp_pkg::cmd_t   cmd
);
	import mexp_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_RED;
			end
			ST_RED: begin
				if (status.mul_last) state_d = ST_RBASE;
			end
			ST_RBASE: state_d = ST_SQS;
			ST_SQS:   state_d = ST_SQ;
			ST_SQ: begin
				if (status.mul_last) state_d = ST_SQT;
			end
			ST_SQT: begin
				if (status.exp_bit) state_d = ST_MLS;
				else if (status.exp_last) state_d = ST_FIN;
				else state_d = ST_ENX;
			end
			ST_MLS: state_d = ST_ML;
			ST_ML: begin
				if (status.mul_last) state_d = ST_MLT;
			end
			ST_MLT: begin
				if (status.exp_last) state_d = ST_FIN;
				else state_d = ST_ENX;
			end
			ST_ENX: state_d = ST_SQS;
			ST_FIN: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_RED:   cmd.step = 1'b1;
			ST_RBASE: cmd.take_base = 1'b1;
			ST_SQS: begin
				cmd.setup = 1'b1;
				cmd.opsel = OP_SQUARE;
			end
			ST_SQ:  cmd.step = 1'b1;
			ST_SQT: cmd.take_acc = 1'b1;
			ST_MLS: begin
				cmd.setup = 1'b1;
				cmd.opsel = OP_MULT;
			end
			ST_ML:  cmd.step = 1'b1;
			ST_MLT: cmd.take_acc = 1'b1;
			ST_ENX: cmd.exp_next = 1'b1;
			ST_FIN: cmd.finish = 1'b1;
			default: busy = 1'b0;
		endcase
	end

endmodule

### rtl/mexp_dp.sv
// Datapath: key registers, accumulator and a bit-serial modular multiplier.
module mexp_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [mexp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mexp_pkg::WIDTH-1:0]         cfg_data,
	input  mexp_pkg::item_t                    item,
	input  mexp_pkg::cmd_t                     cmd,
	output mexp_pkg::status_t                  status,
	output mexp_pkg::result_t                  result,
	output logic                               done
);
	import mexp_pkg::*;

	logic [WIDTH-1:0] mod_q;
	logic [WIDTH-1:0] exp_q;
	logic [WIDTH-1:0] base_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] mul_a_q;
	logic [WIDTH-1:0] mul_b_q;
	logic [WIDTH-1:0] mul_r_q;
	logic [IDX_W-1:0] mcnt_q;
	logic [IDX_W-1:0] ecnt_q;
	logic             last_q;
	result_t          result_q;
	logic             done_q;

	logic [WIDTH+1:0] sum;
	logic [WIDTH+1:0] mod1;
	logic [WIDTH+1:0] mod2;
	logic [WIDTH-1:0] mul_next;

	// 2r + a stays below 3m, so one of three candidates is the residue
	always_comb begin
		mod1 = {2'b00, mod_q};
		mod2 = {1'b0, mod_q, 1'b0};
		sum  = {1'b0, mul_r_q, 1'b0} + (mul_b_q[WIDTH-1] ? {2'b00, mul_a_q} : '0);
		if (sum >= mod2) mul_next = WIDTH'(sum - mod2);
		else if (sum >= mod1) mul_next = WIDTH'(sum - mod1);
		else mul_next = WIDTH'(sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= WIDTH'(1);
			exp_q <= WIDTH'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODULUS:  mod_q <= cfg_data;
				REG_EXPONENT: exp_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		// reduce the base by multiplying it with one
		if (cmd.load) begin
			last_q  <= item.last_item;
			mul_a_q <= WIDTH'(1);
			mul_b_q <= item.base_value;
			mul_r_q <= '0;
			mcnt_q  <= IDX_W'(WIDTH - 1);
			ecnt_q  <= IDX_W'(WIDTH - 1);
		end
		if (cmd.setup) begin
			mul_r_q <= '0;
			mcnt_q  <= IDX_W'(WIDTH - 1);
			mul_b_q <= acc_q;
			case (cmd.opsel)
				OP_SQUARE: mul_a_q <= acc_q;
				OP_MULT:   mul_a_q <= base_q;
				default:   mul_a_q <= acc_q;
			endcase
		end
		if (cmd.step) begin
			mul_r_q <= mul_next;
			mul_b_q <= {mul_b_q[WIDTH-2:0], 1'b0};
			mcnt_q  <= mcnt_q - IDX_W'(1);
		end
		if (cmd.take_base) begin
			base_q <= mul_r_q;
			acc_q  <= (mod_q == WIDTH'(1)) ? '0 : WIDTH'(1);
		end
		if (cmd.take_acc) begin
			acc_q <= mul_r_q;
		end
		if (cmd.exp_next) begin
			ecnt_q <= ecnt_q - IDX_W'(1);
		end
		if (cmd.finish) begin
			result_q.result_value <= (mod_q == '0) ? '0 : acc_q;
			result_q.last_result  <= last_q;
		end
	end

	assign status.mul_last = (mcnt_q == '0);
	assign status.exp_bit  = exp_q[ecnt_q];
	assign status.exp_last = (ecnt_q == '0);
	assign result          = result_q;
	assign done            = done_q;

endmodule

### tb/tb_top.sv
// Self-checking bench for modular_exponentiation: RSA-style keys, directed extremes, random words.
module tb_top;
	import mexp_pkg::*;

	localparam int IDLE_PCT   = 12;
	localparam int END_WAIT   = 2300;
	localparam int CYCLE_CAP  = 3000000;
	localparam int PHASES     = 10;
	localparam int PHASE_LEN  = 25;

	// register indexes past the end of the list, writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

	typedef enum logic {
		W_ITEM,
		W_CFG
	} word_kind_t;

	typedef struct {
		word_kind_t           kind;
		item_t                payload;
		logic [CFG_IDX_W-1:0] idx;
		logic [WIDTH-1:0]     data;
		bit                   calm;
	} sched_word_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	item_t                item_w    = '0;
	logic                 cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WIDTH-1:0]     cfg_data  = '0;
	logic                 busy;
	logic                 done;
	logic                 cfg_ready;
	result_t              result;

	sched_word_t schedule[$];
	result_t     expected_residues[$];
	logic [WIDTH-1:0] key_modulus  = WIDTH'(1);
	logic [WIDTH-1:0] key_exponent = WIDTH'(1);
	int in_flight        = 0;
	int errors           = 0;
	int items_taken      = 0;
	int residues_checked = 0;
	int reg_writes       = 0;
	int cycles           = 0;

	modular_exponentiation i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item_w),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [WIDTH-1:0] modexp_residue(logic [WIDTH-1:0] base,
			logic [WIDTH-1:0] ex, logic [WIDTH-1:0] m);
		logic [63:0] acc;
		logic [63:0] b;
		logic [63:0] mm;
		if (m == '0)
			return '0;
		mm  = 64'(m);
		b   = 64'(base) % mm;
		acc = 64'(1) % mm;
		for (int i = WIDTH - 1; i >= 0; i--) begin
			acc = (acc * acc) % mm;
			if (ex[i])
				acc = (acc * b) % mm;
		end
		return acc[WIDTH-1:0];
	endfunction

	task automatic queue_item(logic [WIDTH-1:0] base, logic last, bit calm);
		sched_word_t w;
		w.kind    = W_ITEM;
		w.payload = '{base_value: base, last_item: last};
		w.idx     = '0;
		w.data    = '0;
		w.calm    = calm;
		schedule.push_back(w);
	endtask

	task automatic queue_write(logic [CFG_IDX_W-1:0] idx, logic [WIDTH-1:0] data);
		sched_word_t w;
		w.kind    = W_CFG;
		w.payload = '0;
		w.idx     = idx;
		w.data    = data;
		w.calm    = 1'b0;
		schedule.push_back(w);
	endtask

	// Driver: items go out with random gaps unless calm; register writes wait for a drained block.
	always @(posedge clk) begin : drive_words
		logic                 took;
		logic                 nxt_start;
		item_t                nxt_item;
		logic                 nxt_cfg_valid;
		logic [CFG_IDX_W-1:0] nxt_idx;
		logic [WIDTH-1:0]     nxt_data;
		if (arst_n) begin
			took          = start && !busy;
			in_flight     = in_flight + int'(took) - int'(done);
			nxt_start     = start && !took;
			nxt_item      = item_w;
			nxt_cfg_valid = cfg_valid && !cfg_ready;
			nxt_idx       = cfg_index;
			nxt_data      = cfg_data;
			if (!nxt_start && !nxt_cfg_valid && schedule.size() != 0) begin
				if (schedule[0].kind == W_ITEM) begin
					if (schedule[0].calm || $urandom_range(99) >= IDLE_PCT) begin
						nxt_start = 1'b1;
						nxt_item  = schedule[0].payload;
						void'(schedule.pop_front());
					end
				end else if (in_flight == 0 && !busy && !took) begin
					nxt_cfg_valid = 1'b1;
					nxt_idx       = schedule[0].idx;
					nxt_data      = schedule[0].data;
					void'(schedule.pop_front());
				end
			end
			start     <= nxt_start;
			item_w    <= nxt_item;
			cfg_valid <= nxt_cfg_valid;
			cfg_index <= nxt_idx;
			cfg_data  <= nxt_data;
		end
	end

	// Monitor: check each residue against the oldest prediction, then track writes and new items.
	always @(posedge clk) begin : watch_block
		result_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_residues.size() == 0) begin
					$display("%0t unexpected result: got value %h last %b", $time,
						result.result_value, result.last_result);
					errors++;
				end else begin
					want = expected_residues.pop_front();
					residues_checked++;
					if (result.result_value !== want.result_value) begin
						$display("%0t result_value mismatch: expected %h got %h", $time,
							want.result_value, result.result_value);
						errors++;
					end
					if (result.last_result !== want.last_result) begin
						$display("%0t last_result mismatch: expected %b got %b", $time,
							want.last_result, result.last_result);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				reg_writes++;
				case (cfg_index)
					REG_MODULUS:  key_modulus  = cfg_data;
					REG_EXPONENT: key_exponent = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy) begin
				items_taken++;
				want.result_value = modexp_residue(item_w.base_value, key_exponent, key_modulus);
				want.last_result  = item_w.last_item;
				expected_residues.push_back(want);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_CAP) begin
			$display("%0t timeout: %0d residues still due, %0d words unsent", $time,
				expected_residues.size(), schedule.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		logic [WIDTH-1:0] m;
		logic [WIDTH-1:0] e;
		logic [WIDTH-1:0] base;
		int msg_left;
		int pick;

		// reset keys: modulus 1 forces every residue to zero
		queue_item(32'hFFFF_FFFF, 1'b1, 1'b0);
		queue_item(32'h0000_0000, 1'b0, 1'b0);
		// small textbook key pair, n = 61 * 53
		queue_write(REG_MODULUS, 32'd3233);
		queue_write(REG_EXPONENT, 32'd17);
		queue_item(32'd65, 1'b0, 1'b0);
		queue_item(32'd0, 1'b0, 1'b0);
		queue_item(32'd1, 1'b0, 1'b0);
		queue_item(32'd3232, 1'b0, 1'b0);
		queue_item(32'd3233, 1'b0, 1'b0);
		queue_item(32'hFFFF_FFFF, 1'b1, 1'b0);
		queue_write(REG_EXPONENT, 32'd2753);
		queue_item(32'd2790, 1'b1, 1'b0);
		// all-ones key
		queue_write(REG_MODULUS, 32'hFFFF_FFFF);
		queue_write(REG_EXPONENT, 32'hFFFF_FFFF);
		queue_item(32'hFFFF_FFFE, 1'b0, 1'b0);
		queue_item(32'h8000_0000, 1'b0, 1'b0);
		queue_item(32'h7FFF_FFFF, 1'b0, 1'b0);
		queue_item(32'hFFFF_FFFF, 1'b1, 1'b0);
		// zero exponent
		queue_write(REG_EXPONENT, 32'd0);
		queue_item(32'd0, 1'b0, 1'b0);
		queue_item(32'hDEAD_BEEF, 1'b1, 1'b0);
		queue_write(REG_MODULUS, 32'd1);
		queue_item(32'd5, 1'b0, 1'b0);
		// modulus zero has no residue
		queue_write(REG_MODULUS, 32'd0);
		queue_write(REG_EXPONENT, 32'd65537);
		queue_item(32'hFFFF_FFFF, 1'b1, 1'b0);
		queue_item(32'd12345, 1'b0, 1'b0);
		// out-of-range indexes must leave the keys alone
		queue_write(REG_MODULUS, 32'hFFFF_FFFB);
		queue_write(REG_SPARE_LO, 32'h1234_5678);
		queue_write(REG_SPARE_HI, 32'hFFFF_FFFF);
		queue_item(32'd2, 1'b0, 1'b0);
		queue_item(32'hFFFF_FFFC, 1'b1, 1'b0);

		msg_left = $urandom_range(1, 8);
		for (int p = 0; p < PHASES; p++) begin
			pick = $urandom_range(9);
			case (pick)
				6:       m = WIDTH'($urandom_range(2, 255));
				7:       m = 32'hFFFF_FFFF;
				8:       m = 32'd1;
				9:       m = (p == 2) ? 32'd0 : ($urandom | 32'h8000_0001);
				default: m = $urandom | 32'h8000_0001;
			endcase
			pick = $urandom_range(9);
			case (pick)
				5:       e = 32'd65537;
				6:       e = 32'd3;
				7:       e = 32'd0;
				8:       e = 32'hFFFF_FFFF;
				9:       e = WIDTH'($urandom_range(1, 255));
				default: e = $urandom;
			endcase
			if ($urandom_range(1)) begin
				queue_write(REG_MODULUS, m);
				queue_write(REG_EXPONENT, e);
			end else begin
				queue_write(REG_EXPONENT, e);
				queue_write(REG_MODULUS, m);
			end
			if ($urandom_range(3) == 0)
				queue_write($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
			for (int k = 0; k < PHASE_LEN; k++) begin
				pick = $urandom_range(9);
				case (pick)
					6:       base = $urandom;
					7:       base = m - 1;
					8:       base = WIDTH'($urandom_range(1));
					9:       base = $urandom_range(1) ? 32'hFFFF_FFFF : m;
					default: base = (m == '0) ? $urandom : ($urandom % m);
				endcase
				msg_left--;
				// phase 4 runs back to back with no gaps
				queue_item(base, msg_left == 0, p == 4);
				if (msg_left == 0)
					msg_left = $urandom_range(1, 8);
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (schedule.size() != 0 || start || expected_residues.size() != 0);
		repeat (END_WAIT) @(negedge clk);

		if (expected_residues.size() != 0) begin
			$display("%0t %0d residues never arrived", $time, expected_residues.size());
			errors++;
		end
		$display("ran %0d items through %0d register writes (%0d key phases plus directed keys)",
			items_taken, reg_writes, PHASES);
		$display("checked %0d residues, %0d mismatches", residues_checked, errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
